// File: src/bqeq_pkg.sv
// Shared types, constants and fixed-point helpers for the biquad cascade equalizer.
package bqeq_pkg;

   localparam int NumBandsDef    = 10;
   localparam int MaxChannelsDef = 2;
   localparam int NumSlots       = 5;
   localparam int MaskBits       = 10;
   localparam int HistRowW       = 128;

   localparam logic [31:0] GainReset = 32'h1000_0000;

   localparam logic CmdSample = 1'b0;
   localparam logic CmdCoef   = 1'b1;

   localparam logic [2:0] SlotB0 = 3'd0;
   localparam logic [2:0] SlotB1 = 3'd1;
   localparam logic [2:0] SlotB2 = 3'd2;
   localparam logic [2:0] SlotA1 = 3'd3;
   localparam logic [2:0] SlotA2 = 3'd4;

   localparam logic [1:0] RegBypass = 2'd0;
   localparam logic [1:0] RegGain   = 2'd1;
   localparam logic [1:0] RegMask   = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic               channel;
      logic signed [15:0] sample_in;
      logic [3:0]         coef_band;
      logic [2:0]         coef_slot;
      logic signed [31:0] coef_value;
      logic               end_of_block;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample_out;
      logic               channel_out;
      logic               end_of_block_out;
   } rsp_type;

   typedef struct packed {
      logic       clr_we;
      logic       pre_mul;
      logic       pre_rnd;
      logic       hist_rd;
      logic       mac_vld;
      logic [2:0] mac_slot;
      logic       wb;
      logic       fin;
      logic       fin_pass;
   } dp_cmd_type;

   // Q.36 product -> Q24.8, round half up, saturate to 32 bits
   function automatic logic signed [31:0] round_q28(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd134217728) >>> 28;
      if (t > 64'sh0000_0000_7FFF_FFFF)
         return 32'sh7FFF_FFFF;
      else if (t < -64'sh0000_0000_8000_0000)
         return 32'sh8000_0000;
      else
         return t[31:0];
   endfunction

   function automatic logic signed [31:0] sat_addsub(input logic signed [31:0] a,
                                                     input logic signed [31:0] b,
                                                     input logic sub);
      logic signed [32:0] s;
      s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
      if (s[32] != s[31])
         return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else
         return s[31:0];
   endfunction

   // Q24.8 -> integer, truncate toward zero, clamp to 16 bits
   function automatic logic signed [15:0] to_out16(input logic signed [31:0] v);
      logic signed [31:0] t;
      t = (v + (v[31] ? 32'sd255 : 32'sd0)) >>> 8;
      if (t > 32'sd32767)
         return 16'sh7FFF;
      else if (t < -32'sd32768)
         return 16'sh8000;
      else
         return t[15:0];
   endfunction

endpackage

// File: src/biquad_cascade_eq_core.sv
// Biquad cascade equalizer top: register port, sequencer, datapath, output register.
// Coefficient beat: no result, and the block stays ready. Bypass or bad channel: sample passed through.
// Filtered sample: preamp multiply and round, then a scan over all NUM_BANDS bands; each enabled
// band sends its five terms through the shared multiplier pipe and writes its history back.
// One sample in flight; the next can be accepted in the cycle after its result is handed off.
// Reset: registers to defaults, then a history clear of all NUM_BANDS*MAX_CHANNELS rows, ready low.
module biquad_cascade_eq_core #(
   parameter int NUM_BANDS    = bqeq_pkg::NumBandsDef,
   parameter int MAX_CHANNELS = bqeq_pkg::MaxChannelsDef
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bqeq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bqeq_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int Rows  = NUM_BANDS * MAX_CHANNELS;
   localparam int RowAw = (Rows > 1) ? $clog2(Rows) : 1;
   localparam int BandW = $clog2(NUM_BANDS + 1);
   localparam int MaskW = bqeq_pkg::MaskBits;

   logic             bypass_ff;
   logic [31:0]      gain_ff;
   logic [MaskW-1:0] mask_ff;
   logic             csr_write;

   logic                 req_accept;
   logic                 out_load, out_free;
   bqeq_pkg::dp_cmd_type dp_cmd;
   logic [BandW-1:0]     band;
   logic [RowAw-1:0]     clr_row;
   bqeq_pkg::rsp_type    result;

   logic              rsp_valid_ff, rsp_valid_in;
   bqeq_pkg::rsp_type rsp_payload_ff;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
         gain_ff   <= bqeq_pkg::GainReset;
         mask_ff   <= '0;
      end else if (csr_write) begin
         case (paddr[3:2])
            bqeq_pkg::RegBypass: bypass_ff <= pwdata[0];
            bqeq_pkg::RegGain:   gain_ff   <= pwdata;
            bqeq_pkg::RegMask:   mask_ff   <= pwdata[MaskW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         bqeq_pkg::RegBypass: prdata = {31'd0, bypass_ff};
         bqeq_pkg::RegGain:   prdata = gain_ff;
         bqeq_pkg::RegMask:   prdata = {{(32 - MaskW){1'b0}}, mask_ff};
         default:             prdata = '0;
      endcase
   end

   assign req_accept = req_valid && req_ready;

   bqeq_ctrl #(
      .NUM_BANDS    (NUM_BANDS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_cmd          (req_payload.cmd),
      .req_channel      (req_payload.channel),
      .bypass_on        (bypass_ff),
      .band_enable_mask (mask_ff),
      .out_free         (out_free),
      .req_ready        (req_ready),
      .out_load         (out_load),
      .dp_cmd           (dp_cmd),
      .band             (band),
      .clr_row          (clr_row)
   );

   bqeq_datapath #(
      .NUM_BANDS    (NUM_BANDS),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_payload (req_payload),
      .dp_cmd      (dp_cmd),
      .band        (band),
      .clr_row     (clr_row),
      .preamp_gain (gain_ff),
      .result      (result)
   );

   // output register: a finished beat waits here while the next sample is taken
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_coef_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.cmd == bqeq_pkg::CmdCoef |=> req_ready)
      else $error("coefficient beat left the block busy");

   a_sample_goes_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.cmd == bqeq_pkg::CmdSample |=> !req_ready)
      else $error("sample beat did not start processing");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending beat");
`endif

endmodule

// File: src/bqeq_ctrl.sv
// Sequencer for the equalizer: history clear, preamp, band scan, MAC issue and result handoff.
module bqeq_ctrl #(
   parameter int NUM_BANDS    = bqeq_pkg::NumBandsDef,
   parameter int MAX_CHANNELS = bqeq_pkg::MaxChannelsDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_cmd,
   input  logic                                 req_channel,
   input  logic                                 bypass_on,
   input  logic [bqeq_pkg::MaskBits-1:0]        band_enable_mask,
   input  logic                                 out_free,
   output logic                                 req_ready,
   output logic                                 out_load,
   output bqeq_pkg::dp_cmd_type                 dp_cmd,
   output logic [$clog2(NUM_BANDS+1)-1:0]       band,
   output logic [((NUM_BANDS*MAX_CHANNELS > 1) ?
                  $clog2(NUM_BANDS*MAX_CHANNELS) : 1)-1:0] clr_row
);

   localparam int Rows   = NUM_BANDS * MAX_CHANNELS;
   localparam int RowAw  = (Rows > 1) ? $clog2(Rows) : 1;
   localparam int BandW  = $clog2(NUM_BANDS + 1);
   localparam int MaskW  = bqeq_pkg::MaskBits;

   localparam logic [3:0] StClear = 4'd0;
   localparam logic [3:0] StIdle  = 4'd1;
   localparam logic [3:0] StPre   = 4'd2;
   localparam logic [3:0] StRnd   = 4'd3;
   localparam logic [3:0] StScan  = 4'd4;
   localparam logic [3:0] StMac   = 4'd5;
   localparam logic [3:0] StDrain = 4'd6;
   localparam logic [3:0] StWb    = 4'd7;
   localparam logic [3:0] StFin   = 4'd8;
   localparam logic [3:0] StDone  = 4'd9;

   // MAC pipeline: coef read, multiply, round, accumulate
   localparam logic [2:0] DrainLast = 3'd2;

   logic [3:0]       state_ff, state_in;
   logic [BandW-1:0] band_ff, band_in;
   logic [2:0]       slot_ff, slot_in;
   logic [RowAw-1:0] clr_ff, clr_in;
   logic             pass_ff, pass_in;
   logic [MaskW-1:0] band_bit;
   logic             band_on;

   assign band_bit = MaskW'(1) << band_ff;
   assign band_on  = |(band_enable_mask & band_bit);

   always_comb begin
      state_in = state_ff;
      band_in  = band_ff;
      slot_in  = slot_ff;
      clr_in   = clr_ff;
      pass_in  = pass_ff;
      req_ready = 1'b0;
      out_load  = 1'b0;
      dp_cmd    = '0;
      case (state_ff)
         StClear: begin
            dp_cmd.clr_we = 1'b1;
            if (clr_ff == RowAw'(Rows - 1)) begin
               state_in = StIdle;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid && req_cmd == bqeq_pkg::CmdSample) begin
               pass_in  = bypass_on || (32'(req_channel) >= 32'(MAX_CHANNELS));
               band_in  = '0;
               state_in = pass_in ? StFin : StPre;
            end
         end
         StPre: begin
            dp_cmd.pre_mul = 1'b1;
            state_in = StRnd;
         end
         StRnd: begin
            dp_cmd.pre_rnd = 1'b1;
            state_in = StScan;
         end
         StScan: begin
            if (band_ff == BandW'(NUM_BANDS)) begin
               state_in = StFin;
            end else if (band_on) begin
               dp_cmd.hist_rd = 1'b1;
               slot_in  = bqeq_pkg::SlotB0;
               state_in = StMac;
            end else begin
               band_in = band_ff + 1'b1;
            end
         end
         StMac: begin
            dp_cmd.mac_vld  = 1'b1;
            dp_cmd.mac_slot = slot_ff;
            if (slot_ff == bqeq_pkg::SlotA2) begin
               slot_in  = '0;
               state_in = StDrain;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         StDrain: begin
            if (slot_ff == DrainLast) begin
               state_in = StWb;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         StWb: begin
            dp_cmd.wb = 1'b1;
            band_in  = band_ff + 1'b1;
            state_in = StScan;
         end
         StFin: begin
            dp_cmd.fin      = 1'b1;
            dp_cmd.fin_pass = pass_ff;
            state_in = StDone;
         end
         StDone: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         band_ff  <= '0;
         slot_ff  <= '0;
         clr_ff   <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         slot_ff  <= slot_in;
         clr_ff   <= clr_in;
         pass_ff  <= pass_in;
      end
   end

   assign band    = band_ff;
   assign clr_row = clr_ff;

endmodule

// File: src/bqeq_datapath.sv
// Equalizer datapath: coefficient and history memories, shared multiplier, rounding, accumulator.
module bqeq_datapath #(
   parameter int NUM_BANDS    = bqeq_pkg::NumBandsDef,
   parameter int MAX_CHANNELS = bqeq_pkg::MaxChannelsDef
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_accept,
   input  bqeq_pkg::req_type                    req_payload,
   input  bqeq_pkg::dp_cmd_type                 dp_cmd,
   input  logic [$clog2(NUM_BANDS+1)-1:0]       band,
   input  logic [((NUM_BANDS*MAX_CHANNELS > 1) ?
                  $clog2(NUM_BANDS*MAX_CHANNELS) : 1)-1:0] clr_row,
   input  logic [31:0]                          preamp_gain,
   output bqeq_pkg::rsp_type                    result
);

   localparam int Rows      = NUM_BANDS * MAX_CHANNELS;
   localparam int RowAw     = (Rows > 1) ? $clog2(Rows) : 1;
   localparam int CoefDepth = NUM_BANDS * bqeq_pkg::NumSlots;
   localparam int CoefAw    = $clog2(CoefDepth);
   localparam int HistW     = bqeq_pkg::HistRowW;

   logic signed [31:0] coef_mem [CoefDepth];
   logic [HistW-1:0]   hist_mem [Rows];

   logic               chan_ff;
   logic signed [15:0] samp_ff;
   logic               eob_ff;

   logic               coef_we;
   logic [CoefAw-1:0]  coef_wa, coef_ra;
   logic signed [31:0] coef_q_ff;
   logic [RowAw-1:0]   hist_ra, row_ff, hist_wa;
   logic               hist_we;
   logic [HistW-1:0]   hist_q_ff, hist_wd;
   logic signed [31:0] x1, x2, y1, y2, operand;

   logic               vld_d1_ff, vld_d2_ff, vld_d3_ff;
   logic [2:0]         slot_d1_ff, slot_d2_ff, slot_d3_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_full;
   logic signed [63:0] prod_ff;
   logic signed [31:0] term_ff, acc_ff, v_ff;
   logic signed [15:0] result_ff;

   // item capture
   always_ff @(posedge clock) begin
      if (req_accept && req_payload.cmd == bqeq_pkg::CmdSample) begin
         chan_ff <= req_payload.channel;
         samp_ff <= req_payload.sample_in;
         eob_ff  <= req_payload.end_of_block;
      end
   end

   // coefficient memory
   assign coef_we = req_accept && req_payload.cmd == bqeq_pkg::CmdCoef &&
                    (32'(req_payload.coef_band) < 32'(NUM_BANDS)) &&
                    (32'(req_payload.coef_slot) < 32'(bqeq_pkg::NumSlots));
   assign coef_wa = CoefAw'(32'(req_payload.coef_band) * bqeq_pkg::NumSlots +
                            32'(req_payload.coef_slot));
   assign coef_ra = CoefAw'(32'(band) * bqeq_pkg::NumSlots + 32'(dp_cmd.mac_slot));

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= req_payload.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.mac_vld) begin
         coef_q_ff <= coef_mem[coef_ra];
      end
   end

   // history memory: one row per band and channel, {x1, x2, y1, y2}
   assign hist_ra = RowAw'(32'(band) * MAX_CHANNELS + 32'(chan_ff));
   assign hist_we = dp_cmd.clr_we || dp_cmd.wb;
   assign hist_wa = dp_cmd.clr_we ? clr_row : row_ff;
   assign hist_wd = dp_cmd.clr_we ? '0 : {v_ff, x1, acc_ff, y1};

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.hist_rd) begin
         hist_q_ff <= hist_mem[hist_ra];
         row_ff    <= hist_ra;
      end
   end

   assign x1 = hist_q_ff[127:96];
   assign x2 = hist_q_ff[95:64];
   assign y1 = hist_q_ff[63:32];
   assign y2 = hist_q_ff[31:0];

   always_comb begin
      case (slot_d1_ff)
         bqeq_pkg::SlotB0: operand = v_ff;
         bqeq_pkg::SlotB1: operand = x1;
         bqeq_pkg::SlotB2: operand = x2;
         bqeq_pkg::SlotA1: operand = y1;
         bqeq_pkg::SlotA2: operand = y2;
         default:          operand = '0;
      endcase
   end

   // slot tags follow each term down the MAC pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d1_ff <= 1'b0;
         vld_d2_ff <= 1'b0;
         vld_d3_ff <= 1'b0;
      end else begin
         vld_d1_ff <= dp_cmd.mac_vld;
         vld_d2_ff <= vld_d1_ff;
         vld_d3_ff <= vld_d2_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_d1_ff <= dp_cmd.mac_slot;
      slot_d2_ff <= slot_d1_ff;
      slot_d3_ff <= slot_d2_ff;
   end

   // shared multiplier; preamp gain is unsigned so it gets a zero sign bit
   always_comb begin
      if (dp_cmd.pre_mul) begin
         mul_a = {{9{samp_ff[15]}}, samp_ff, 8'h00};
         mul_b = {1'b0, preamp_gain};
      end else begin
         mul_a = {coef_q_ff[31], coef_q_ff};
         mul_b = {operand[31], operand};
      end
   end

   assign prod_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (dp_cmd.pre_mul || vld_d1_ff) begin
         prod_ff <= prod_full[63:0];
      end
      if (vld_d2_ff) begin
         term_ff <= bqeq_pkg::round_q28(prod_ff);
      end
      if (vld_d3_ff) begin
         case (slot_d3_ff)
            bqeq_pkg::SlotB0: acc_ff <= term_ff;
            bqeq_pkg::SlotB1,
            bqeq_pkg::SlotB2: acc_ff <= bqeq_pkg::sat_addsub(acc_ff, term_ff, 1'b0);
            bqeq_pkg::SlotA1,
            bqeq_pkg::SlotA2: acc_ff <= bqeq_pkg::sat_addsub(acc_ff, term_ff, 1'b1);
            default:          acc_ff <= acc_ff;
         endcase
      end
      if (dp_cmd.pre_rnd) begin
         v_ff <= bqeq_pkg::round_q28(prod_ff);
      end else if (dp_cmd.wb) begin
         v_ff <= acc_ff;
      end
      if (dp_cmd.fin) begin
         result_ff <= dp_cmd.fin_pass ? samp_ff : bqeq_pkg::to_out16(v_ff);
      end
   end

   assign result.sample_out       = result_ff;
   assign result.channel_out      = chan_ff;
   assign result.end_of_block_out = eob_ff;

endmodule

// File: bench/tb.sv
// Self-checking bench for the biquad cascade equalizer core: stimulus, prediction, scoreboard.
`timescale 1ns / 100ps

module tb;

   localparam int NumBands   = bqeq_pkg::NumBandsDef;
   localparam int MaxCh      = bqeq_pkg::MaxChannelsDef;
   localparam int HistDepth  = bqeq_pkg::NumBandsDef * bqeq_pkg::MaxChannelsDef * 2;
   localparam int StallLimit = 3000;
   localparam int DrainPause = 120;
   localparam int HoldCycles = 400;
   localparam logic [31:0] GainMax  = 32'hFFFF_FFFF;
   localparam logic [9:0]  MaskAll  = 10'h3FF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bqeq_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready;
   bqeq_pkg::rsp_type rsp_payload;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [3:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   biquad_cascade_eq_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #2 clock = ~clock;

   // mirror of the block's configuration and state
   logic               eq_bypass = 1'b0;
   logic [31:0]        eq_gain   = bqeq_pkg::GainReset;
   logic [9:0]         eq_mask   = '0;
   logic signed [31:0] coef_mem  [NumBands*bqeq_pkg::NumSlots];
   logic signed [31:0] x_hist    [HistDepth];
   logic signed [31:0] y_hist    [HistDepth];

   bqeq_pkg::rsp_type expected_out_q [$];
   int                err_count = 0;
   int                idle_cycles = 0;

   logic req_idle_on = 1'b1;
   logic rsp_idle_on = 1'b1;
   logic rsp_hold_pending = 1'b0;

   // ---------------- fixed-point predictor ----------------

   function automatic logic signed [31:0] sat32(input longint v);
      if (v > 64'sd2147483647)
         return 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648)
         return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Q.36 -> Q24.8, round half up (floor after adding half an lsb)
   function automatic logic signed [31:0] q28_round(input longint p);
      longint t;
      t = (p + 64'sd134217728) >>> 28;
      return sat32(t);
   endfunction

   function automatic logic signed [31:0] q28_mul(input logic signed [31:0] c,
                                                  input logic signed [31:0] s);
      return q28_round(longint'(c) * longint'(s));
   endfunction

   function automatic logic signed [31:0] acc_sat(input logic signed [31:0] acc,
                                                  input logic signed [31:0] term,
                                                  input logic neg);
      if (neg)
         return sat32(longint'(acc) - longint'(term));
      return sat32(longint'(acc) + longint'(term));
   endfunction

   task automatic equalize(input bqeq_pkg::req_type r);
      bqeq_pkg::rsp_type  o;
      logic signed [31:0] v;
      logic signed [31:0] y;
      int                 k;
      int                 h;
      int                 res;
      if (r.cmd == bqeq_pkg::CmdCoef) begin
         if (r.coef_band < NumBands && r.coef_slot < bqeq_pkg::NumSlots)
            coef_mem[r.coef_band * bqeq_pkg::NumSlots + r.coef_slot] = r.coef_value;
         return;
      end
      o.channel_out      = r.channel;
      o.end_of_block_out = r.end_of_block;
      if (eq_bypass || r.channel >= MaxCh) begin
         o.sample_out = r.sample_in;
      end else begin
         v = q28_round(longint'($signed(r.sample_in)) * 256 * longint'({32'd0, eq_gain}));
         for (int b = 0; b < NumBands; b++) begin
            if (b < bqeq_pkg::MaskBits && eq_mask[b]) begin
               k = b * bqeq_pkg::NumSlots;
               h = (b * MaxCh + r.channel) * 2;
               y = q28_mul(coef_mem[k + bqeq_pkg::SlotB0], v);
               y = acc_sat(y, q28_mul(coef_mem[k + bqeq_pkg::SlotB1], x_hist[h]), 1'b0);
               y = acc_sat(y, q28_mul(coef_mem[k + bqeq_pkg::SlotB2], x_hist[h + 1]), 1'b0);
               y = acc_sat(y, q28_mul(coef_mem[k + bqeq_pkg::SlotA1], y_hist[h]), 1'b1);
               y = acc_sat(y, q28_mul(coef_mem[k + bqeq_pkg::SlotA2], y_hist[h + 1]), 1'b1);
               x_hist[h + 1] = x_hist[h];
               x_hist[h]     = v;
               y_hist[h + 1] = y_hist[h];
               y_hist[h]     = y;
               v = y;
            end
         end
         res = int'(v) / 256;   // truncates toward zero
         if (res > 32767)
            res = 32767;
         if (res < -32768)
            res = -32768;
         o.sample_out = 16'(res);
      end
      expected_out_q.push_back(o);
   endtask

   // ---------------- stimulus helpers ----------------

   function automatic bqeq_pkg::req_type make_sample(input logic ch,
                                                     input logic signed [15:0] s,
                                                     input logic eob);
      bqeq_pkg::req_type r;
      r.cmd          = bqeq_pkg::CmdSample;
      r.channel      = ch;
      r.sample_in    = s;
      r.coef_band    = 4'($urandom);
      r.coef_slot    = 3'($urandom);
      r.coef_value   = $urandom;
      r.end_of_block = eob;
      return r;
   endfunction

   function automatic bqeq_pkg::req_type make_coef(input logic [3:0] band,
                                                   input logic [2:0] slot,
                                                   input logic signed [31:0] val);
      bqeq_pkg::req_type r;
      r.cmd          = bqeq_pkg::CmdCoef;
      r.channel      = 1'($urandom);
      r.sample_in    = 16'($urandom);
      r.coef_band    = band;
      r.coef_slot    = slot;
      r.coef_value   = val;
      r.end_of_block = 1'($urandom);
      return r;
   endfunction

   // mostly stable sections; now and then anything, or a rail value
   function automatic logic signed [31:0] pick_coef(input logic [2:0] slot);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return $urandom;
      if (pick == 1)
         return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      case (slot)
         bqeq_pkg::SlotB0: return $urandom_range(32'h0400_0000, 32'h1800_0000);
         bqeq_pkg::SlotA2: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
         default:          return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
      endcase
   endfunction

   function automatic logic signed [15:0] pick_sample();
      if ($urandom_range(0, 3) == 0)
         return 16'($signed($urandom_range(0, 510)) - 255);
      return 16'($urandom);
   endfunction

   function automatic bqeq_pkg::req_type random_item();
      logic [3:0] band;
      logic [2:0] slot;
      if ($urandom_range(0, 99) < 12) begin
         band = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15)) :
                                              4'($urandom_range(0, 9));
         slot = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                                              3'($urandom_range(0, 4));
         return make_coef(band, slot, pick_coef(slot));
      end
      return make_sample(1'($urandom), pick_sample(), 1'($urandom));
   endfunction

   // ---------------- drivers ----------------

   task automatic send_req(input bqeq_pkg::req_type item);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      equalize(item);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         bqeq_pkg::RegBypass: eq_bypass = val[0];
         bqeq_pkg::RegGain:   eq_gain   = val;
         bqeq_pkg::RegMask:   eq_mask   = val[9:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // quiet the input and let the block finish, then a short pause for coefficient beats
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_config(input logic byp, input logic [31:0] gain, input logic [9:0] mask);
      settle();
      csr_write(bqeq_pkg::RegBypass, {31'd0, byp});
      csr_write(bqeq_pkg::RegGain, gain);
      csr_write(bqeq_pkg::RegMask, {22'd0, mask});
   endtask

   task automatic send_extreme_samples();
      send_req(make_sample(1'b0, 16'sh7FFF, 1'b0));
      send_req(make_sample(1'b1, 16'sh8000, 1'b1));
      send_req(make_sample(1'b0, 16'sh8000, 1'b0));
      send_req(make_sample(1'b1, 16'sh7FFF, 1'b0));
      send_req(make_sample(1'b0, 16'sh0000, 1'b1));
      send_req(make_sample(1'b1, -16'sd1, 1'b0));
   endtask

   // ---------------- tests ----------------

   task automatic test_no_bands();
      // defaults: gain 1.0, no band enabled
      send_extreme_samples();
      send_req(make_sample(1'b0, 16'sd1, 1'b1));
   endtask

   task automatic test_coef_load();
      for (int b = 0; b < NumBands; b++)
         for (int s = 0; s < bqeq_pkg::NumSlots; s++)
            send_req(make_coef(4'(b), 3'(s), pick_coef(3'(s))));
      // out of range band or slot: dropped
      send_req(make_coef(4'd10, bqeq_pkg::SlotB0, 32'sh7FFF_FFFF));
      send_req(make_coef(4'd15, bqeq_pkg::SlotA2, 32'sh8000_0000));
      send_req(make_coef(4'd2, 3'd5, 32'sh7FFF_FFFF));
      send_req(make_coef(4'd2, 3'd7, 32'sh8000_0000));
   endtask

   task automatic test_extremes();
      set_config(1'b0, bqeq_pkg::GainReset, MaskAll);
      send_extreme_samples();
      set_config(1'b0, GainMax, MaskAll);
      send_extreme_samples();
      set_config(1'b0, 32'd0, MaskAll);
      send_req(make_sample(1'b0, 16'sh7FFF, 1'b0));
      send_req(make_sample(1'b1, 16'sh8000, 1'b1));
      set_config(1'b1, GainMax, MaskAll);
      send_extreme_samples();
      // rail coefficients in one band
      set_config(1'b0, bqeq_pkg::GainReset, 10'h008);
      send_req(make_coef(4'd3, bqeq_pkg::SlotB1, 32'sh8000_0000));
      send_req(make_coef(4'd3, bqeq_pkg::SlotB2, 32'sh7FFF_FFFF));
      send_req(make_coef(4'd3, bqeq_pkg::SlotA1, 32'sh8000_0000));
      send_extreme_samples();
      for (int s = 0; s < bqeq_pkg::NumSlots; s++)
         send_req(make_coef(4'd3, 3'(s), pick_coef(3'(s))));
   endtask

   task automatic test_random_phases();
      logic        byp;
      logic [31:0] gain;
      logic [9:0]  mask;
      for (int ph = 0; ph < 8; ph++) begin
         byp = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 4))
            0:       gain = bqeq_pkg::GainReset;
            1:       gain = 32'd0;
            2:       gain = GainMax;
            default: gain = $urandom_range(32'h0400_0000, 32'h2000_0000);
         endcase
         case ($urandom_range(0, 3))
            0:       mask = '0;
            1:       mask = MaskAll;
            default: mask = 10'($urandom);
         endcase
         set_config(byp, gain, mask);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat (185) send_req(random_item());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      set_config(1'b0, bqeq_pkg::GainReset, MaskAll);
      req_idle_on      = 1'b0;
      rsp_hold_pending = 1'b1;
      repeat (40) send_req(make_sample(1'($urandom), pick_sample(), 1'($urandom)));
      req_idle_on = 1'b1;
   endtask

   // ---------------- result side ----------------

   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_pending) begin
            stall = HoldCycles;
            rsp_hold_pending = 1'b0;
         end else begin
            stall = rsp_idle_on ? $urandom_range(0, 12) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      bqeq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out_q.size() == 0) begin
            $error("unexpected result beat: sample_out %0d", rsp_payload.sample_out);
            err_count++;
         end else begin
            want = expected_out_q.pop_front();
            if (rsp_payload.sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, got %0d", want.sample_out,
                      rsp_payload.sample_out);
               err_count++;
            end
            if (rsp_payload.channel_out !== want.channel_out) begin
               $error("channel_out: expected %0d, got %0d", want.channel_out,
                      rsp_payload.channel_out);
               err_count++;
            end
            if (rsp_payload.end_of_block_out !== want.end_of_block_out) begin
               $error("end_of_block_out: expected %0d, got %0d", want.end_of_block_out,
                      rsp_payload.end_of_block_out);
               err_count++;
            end
         end
      end
   end

   // watchdog: cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < HistDepth; i++) begin
         x_hist[i] = '0;
         y_hist[i] = '0;
      end
      for (int i = 0; i < NumBands * bqeq_pkg::NumSlots; i++)
         coef_mem[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_no_bands();
      test_coef_load();
      test_extremes();
      test_random_phases();
      test_backpressure();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_out_q.size() != 0) @(posedge clock);
      repeat (DrainPause) @(posedge clock);
      if (err_count == 0 && expected_out_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
